>>> rtl/krt_pkg.sv
// krt_pkg: types, constants and helper functions shared by the keyed record table
// used by krt_front, krt_engine and keyed_record_table; no dependencies
package krt_pkg;

   localparam int CAPACITY    = 32;
   localparam int TAG_BITS    = 32;
   localparam int MAX_RESULTS = 32;
   localparam int KEY_W       = 32;
   localparam int OUT_TAG_W   = 32;
   localparam int FILL_W      = 6;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_LIST   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_LOOKUP,
      OP_REMOVE,
      OP_LIST
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_SHIFT,
      ENG_LIST
   } eng_state_type;

   typedef struct packed {
      func_type                  func;
      logic signed [KEY_W-1:0]   record_key;
      logic [31:0]               record_tag;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [KEY_W-1:0]   found_key;
      logic [OUT_TAG_W-1:0]      found_tag;
      logic [FILL_W-1:0]         fill_count;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      op_type                    op;
      logic signed [KEY_W-1:0]   key;
      logic [TAG_BITS-1:0]       tag;
   } cmd_type;

   function automatic logic [TAG_BITS-1:0] tag_from_req(input logic [31:0] t);
      logic [63:0] w;
      w = 64'(t);
      return w[TAG_BITS-1:0];
   endfunction

   function automatic logic [OUT_TAG_W-1:0] tag_to_rsp(input logic [TAG_BITS-1:0] t);
      logic [63:0] w;
      w = 64'(t);
      return w[OUT_TAG_W-1:0];
   endfunction

   function automatic rsp_type make_rsp(input status_type           status,
                                        input logic signed [KEY_W-1:0] key,
                                        input logic [OUT_TAG_W-1:0] tag,
                                        input logic [CNT_W-1:0]     cnt,
                                        input logic                 last);
      rsp_type     r;
      logic [63:0] w;
      w            = 64'(cnt);
      r.status     = status;
      r.found_key  = key;
      r.found_tag  = tag;
      r.fill_count = w[FILL_W-1:0];
      r.last       = last;
      return r;
   endfunction

endpackage

>>> rtl/keyed_record_table.sv
// keyed_record_table: top level of the keyed record table
// depends on krt_pkg, krt_front and krt_engine
//
// Requests arrive on req_valid/req_ready with req (func, record_key,
// record_tag); results leave on rsp_valid/rsp_ready with rsp (status,
// found_key, found_tag, fill_count, last). Both are valid/ready channels.
// A two-entry queue holds classified requests ahead of the engine, so the
// block keeps taking requests while a result waits in the output register.
// Insert: one result, registered in the cycle after the engine takes it.
// Lookup and remove: a linear search through the record store, one record
// a cycle; remove then moves each later record down one slot, one a cycle,
// before the next request starts. List: after a registered read, one result
// per cycle while rsp_ready is high, at most 32 results, the final one with
// last set; an empty table gives one not-found result. Reset empties the
// table and the queue at once; no clearing pass is needed. When
// rsp_ready is low the engine holds its work and the queue fills, then
// req_ready drops.
module keyed_record_table import krt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   krt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   krt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != STATUS_OK |-> rsp.found_key == '0 && rsp.found_tag == '0)
      else $error("failed result carries a record");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == STATUS_FULL |-> rsp.last && rsp.fill_count == FILL_W'(CAPACITY))
      else $error("full reported below capacity");

   a_queue_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> cmd_valid)
      else $error("request stalled with an empty queue");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("engine took a command from an empty queue");

endmodule

>>> rtl/krt_front.sv
// krt_front: accepts requests, classifies them into commands and queues them
// depends on krt_pkg
module krt_front import krt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] qcnt_ff, qcnt_in;
   logic              push;
   cmd_type           classified;

   always_comb begin
      classified.key = req.record_key;
      classified.tag = tag_from_req(req.record_tag);
      case (req.func)
         FUNC_INSERT: classified.op = OP_INSERT;
         FUNC_LOOKUP: classified.op = OP_LOOKUP;
         FUNC_REMOVE: classified.op = OP_REMOVE;
         FUNC_LIST:   classified.op = OP_LIST;
         default:     classified.op = OP_LIST;
      endcase
   end

   assign req_ready = (qcnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (qcnt_ff != '0);
   assign cmd       = q_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = cmd_pop ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      qcnt_in = qcnt_ff;
      if (push && !cmd_pop) begin
         qcnt_in = QCNT_W'(qcnt_ff + 1'b1);
      end else if (!push && cmd_pop) begin
         qcnt_in = QCNT_W'(qcnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         qcnt_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= classified;
      end
   end

endmodule

>>> rtl/krt_engine.sv
// krt_engine: record store, search and shift sequencer and result register
// depends on krt_pkg
module krt_engine import krt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic [KEY_W-1:0]    key_mem [CAPACITY];
   logic [TAG_BITS-1:0] tag_mem [CAPACITY];

   eng_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    pidx_ff, pidx_in;
   logic                pend_ff, pend_in;
   cmd_type             cmd_ff, cmd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [KEY_W-1:0]    rd_key_ff;
   logic [TAG_BITS-1:0] rd_tag_ff;

   logic                mem_we, mem_re;
   logic [IDX_W-1:0]    mem_waddr;
   logic [KEY_W-1:0]    mem_wkey;
   logic [TAG_BITS-1:0] mem_wtag;
   logic                out_free, hit, emit_now, list_last;
   logic [CNT_W-1:0]    list_lim, pnext, shift_addr;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign hit        = pend_ff && (rd_key_ff == cmd_ff.key);
   assign list_lim   = (int'(cnt_ff) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : cnt_ff;
   assign pnext      = CNT_W'(pidx_ff + 1'b1);
   assign shift_addr = CNT_W'(pidx_ff - 1'b1);
   assign list_last  = (pnext == list_lim);
   assign emit_now   = pend_ff && out_free;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pidx_in      = pidx_ff;
      pend_in      = pend_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = cnt_ff[IDX_W-1:0];
      mem_wkey     = cmd.key;
      mem_wtag     = cmd.tag;
      case (state_ff)
         ENG_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               idx_in  = '0;
               pend_in = 1'b0;
               case (cmd.op)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ff == CNT_W'(CAPACITY)) begin
                        rsp_in = make_rsp(STATUS_FULL, '0, '0, cnt_ff, 1'b1);
                     end else begin
                        mem_we = 1'b1;
                        cnt_in = CNT_W'(cnt_ff + 1'b1);
                        rsp_in = make_rsp(STATUS_OK, cmd.key, tag_to_rsp(cmd.tag),
                                          CNT_W'(cnt_ff + 1'b1), 1'b1);
                     end
                  end
                  OP_LOOKUP, OP_REMOVE: begin
                     state_in = ENG_SCAN;
                  end
                  OP_LIST: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(STATUS_MISS, '0, '0, cnt_ff, 1'b1);
                     end else begin
                        state_in = ENG_LIST;
                     end
                  end
                  default: state_in = ENG_IDLE;
               endcase
            end
         end
         ENG_SCAN: begin
            if (idx_ff < cnt_ff) begin
               mem_re  = 1'b1;
               idx_in  = CNT_W'(idx_ff + 1'b1);
               pidx_in = idx_ff;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (hit) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff.op == OP_REMOVE) begin
                  rsp_in   = make_rsp(STATUS_OK, rd_key_ff, tag_to_rsp(rd_tag_ff),
                                      CNT_W'(cnt_ff - 1'b1), 1'b1);
                  state_in = ENG_SHIFT;
               end else begin
                  rsp_in   = make_rsp(STATUS_OK, rd_key_ff, tag_to_rsp(rd_tag_ff),
                                      cnt_ff, 1'b1);
                  state_in = ENG_IDLE;
               end
            end else if (!pend_ff && idx_ff >= cnt_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_MISS, '0, '0, cnt_ff, 1'b1);
               state_in     = ENG_IDLE;
            end
         end
         ENG_SHIFT: begin
            // record at pidx moves down one slot
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = shift_addr[IDX_W-1:0];
               mem_wkey  = rd_key_ff;
               mem_wtag  = rd_tag_ff;
            end
            if (idx_ff < cnt_ff) begin
               mem_re  = 1'b1;
               idx_in  = CNT_W'(idx_ff + 1'b1);
               pidx_in = idx_ff;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (!pend_ff && idx_ff >= cnt_ff) begin
               cnt_in   = CNT_W'(cnt_ff - 1'b1);
               state_in = ENG_IDLE;
            end
         end
         ENG_LIST: begin
            if (emit_now) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_OK, rd_key_ff, tag_to_rsp(rd_tag_ff),
                                       cnt_ff, list_last);
            end
            if (idx_ff < list_lim && (!pend_ff || emit_now)) begin
               mem_re  = 1'b1;
               idx_in  = CNT_W'(idx_ff + 1'b1);
               pidx_in = idx_ff;
               pend_in = 1'b1;
            end else if (emit_now) begin
               pend_in = 1'b0;
            end
            if (emit_now && list_last) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      cmd_ff  <= cmd_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wkey;
         tag_mem[mem_waddr] <= mem_wtag;
      end
      if (mem_re) begin
         rd_key_ff <= key_mem[idx_ff[IDX_W-1:0]];
         rd_tag_ff <= tag_mem[idx_ff[IDX_W-1:0]];
      end
   end

endmodule
